[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Opcodes and sequencer states.
// ----------------------------------------------------------------------------
package rau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_FORM,
        ST_GCD_INIT,
        ST_MOD,
        ST_DIVN_INIT,
        ST_DIVN,
        ST_DIVD_INIT,
        ST_DIVD,
        ST_DONE
    } t_state;

endpackage

[rtl/rational_arith_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit: add, subtract, multiply, divide, compare fractions
// Results are reduced by a Euclid GCD on a shared bit-serial 64-bit divider.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  command   i_start, o_busy, i_opcode, i_lhs_*, i_rhs_*    in
//  result    o_valid, o_res_num, o_res_den, o_is_*          out
//
//  A transaction is taken when i_start is high and o_busy is low.
//  Two or three 33x33 products, then n/d is formed, then the GCD: each
//  remainder step is a setup state plus a bit-serial shift-subtract division,
//  at most about 92 steps, one final check, then two more divisions.
//  Compare strobes after its two products; unused opcodes go straight to done.
//  o_valid pulses for one cycle; the receiver cannot stall.
//  Synchronous active-low reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module rational_arith_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_lhs_num,
    input  logic [30:0]        i_lhs_den,
    input  logic signed [31:0] i_rhs_num,
    input  logic [30:0]        i_rhs_den,
    output logic               o_valid,
    output logic signed [63:0] o_res_num,
    output logic [62:0]        o_res_den,
    output logic               o_is_greater,
    output logic               o_is_equal,
    output logic               o_is_less
);

    rau_pkg::t_state r_state, n_state;

    logic [2:0]         r_op;
    logic signed [31:0] r_a, r_c;
    logic [30:0]        r_b, r_d;
    logic signed [63:0] r_p1, r_p2, r_p3;
    logic [63:0]        r_mn, r_md, r_x, r_y;
    logic               r_neg;
    // shared divider
    logic [63:0]        r_q, r_rem, r_dvs;
    logic [6:0]         r_cnt;
    logic [63:0]        r_out_num;
    logic [62:0]        r_out_den;
    logic               r_gt, r_eq, r_lt, r_valid;

    // one multiplier, shared by the ST_MUL1, ST_MUL2 and ST_MUL3 states
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic [64:0]        w_trial;
    logic [63:0]        w_rem_sh;
    logic signed [63:0] w_n, w_dd;

    always_comb begin
        w_ma = 33'sd0;
        w_mb = 33'sd0;
        case (r_state)
            rau_pkg::ST_MUL1: begin
                w_ma = {r_a[31], r_a};
                w_mb = (r_op == rau_pkg::OP_MUL) ? {r_c[31], r_c} : {2'b00, r_d};
            end
            rau_pkg::ST_MUL2: begin
                w_ma = {r_c[31], r_c};
                w_mb = {2'b00, r_b};
            end
            rau_pkg::ST_MUL3: begin
                w_ma = {2'b00, r_b};
                w_mb = (r_op == rau_pkg::OP_DIV) ? {r_c[31], r_c} : {2'b00, r_d};
            end
            default: ;
        endcase
    end
    assign w_prod   = w_ma * w_mb;
    assign w_rem_sh = {r_rem[62:0], r_q[63]};
    assign w_trial  = {1'b0, w_rem_sh} - {1'b0, r_dvs};

    always_comb begin
        w_n  = r_p1;
        w_dd = r_p3;
        case (r_op)
            rau_pkg::OP_ADD: w_n = r_p1 + r_p2;
            rau_pkg::OP_SUB: w_n = r_p1 - r_p2;
            rau_pkg::OP_DIV: begin
                if (r_c == 32'sd0) begin
                    w_n  = 64'(r_a);
                    w_dd = {33'd0, r_b};
                end else if (r_c < 32'sd0) begin
                    w_n  = -r_p1;
                    w_dd = -r_p3;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::ST_IDLE:
                if (i_start) n_state = (i_opcode > rau_pkg::OP_CMP) ? rau_pkg::ST_DONE
                                       : rau_pkg::ST_MUL1;
            rau_pkg::ST_MUL1:  n_state = (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB
                                   || r_op == rau_pkg::OP_CMP) ? rau_pkg::ST_MUL2
                                   : rau_pkg::ST_MUL3;
            rau_pkg::ST_MUL2:  n_state = (r_op == rau_pkg::OP_CMP) ? rau_pkg::ST_DONE
                                   : rau_pkg::ST_MUL3;
            rau_pkg::ST_MUL3:  n_state = rau_pkg::ST_FORM;
            rau_pkg::ST_FORM:  n_state = rau_pkg::ST_GCD_INIT;
            rau_pkg::ST_GCD_INIT:
                n_state = (r_y == 64'd0) ? rau_pkg::ST_DIVN_INIT : rau_pkg::ST_MOD;
            rau_pkg::ST_MOD:   if (r_cnt == 7'd0) n_state = rau_pkg::ST_GCD_INIT;
            rau_pkg::ST_DIVN_INIT: n_state = rau_pkg::ST_DIVN;
            rau_pkg::ST_DIVN:  if (r_cnt == 7'd0) n_state = rau_pkg::ST_DIVD_INIT;
            rau_pkg::ST_DIVD_INIT: n_state = rau_pkg::ST_DIVD;
            rau_pkg::ST_DIVD:  if (r_cnt == 7'd0) n_state = rau_pkg::ST_DONE;
            rau_pkg::ST_DONE:  n_state = rau_pkg::ST_IDLE;
            default:           n_state = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == rau_pkg::ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rau_pkg::ST_IDLE: begin
                r_op  <= i_opcode;
                r_a   <= i_lhs_num;
                r_b   <= (i_lhs_den == 31'd0) ? 31'd1 : i_lhs_den;
                r_c   <= i_rhs_num;
                r_d   <= (i_rhs_den == 31'd0) ? 31'd1 : i_rhs_den;
                r_out_num <= 64'd0;
                r_out_den <= 63'd1;
                r_gt <= 1'b0;
                r_eq <= 1'b0;
                r_lt <= 1'b0;
            end
            rau_pkg::ST_MUL1: r_p1 <= w_prod[63:0];
            rau_pkg::ST_MUL2: begin
                r_p2 <= w_prod[63:0];
                if (r_op == rau_pkg::OP_CMP) begin
                    r_gt <= r_p1 > $signed(w_prod[63:0]);
                    r_eq <= r_p1 == $signed(w_prod[63:0]);
                    r_lt <= r_p1 < $signed(w_prod[63:0]);
                end
            end
            rau_pkg::ST_MUL3: r_p3 <= w_prod[63:0];
            rau_pkg::ST_FORM: begin
                r_mn  <= w_n[63] ? 64'(-w_n) : 64'(w_n);
                r_md  <= 64'(w_dd);
                r_x   <= w_n[63] ? 64'(-w_n) : 64'(w_n);
                r_y   <= 64'(w_dd);
                r_neg <= w_n[63];
            end
            rau_pkg::ST_GCD_INIT: begin
                if (r_y == 64'd0) begin
                    if (r_x == 64'd0) r_x <= 64'd1;
                end else begin
                    r_q   <= r_x;
                    r_rem <= 64'd0;
                    r_dvs <= r_y;
                    r_cnt <= 7'd63;
                end
            end
            rau_pkg::ST_MOD, rau_pkg::ST_DIVN, rau_pkg::ST_DIVD: begin
                if (!w_trial[64]) begin
                    r_rem <= w_trial[63:0];
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_q   <= {r_q[62:0], 1'b0};
                end
                if (r_cnt != 7'd0) begin
                    r_cnt <= r_cnt - 7'd1;
                end else if (r_state == rau_pkg::ST_MOD) begin
                    r_x <= r_y;
                    r_y <= w_trial[64] ? w_rem_sh : w_trial[63:0];
                end else if (r_state == rau_pkg::ST_DIVN) begin
                    r_mn <= {r_q[62:0], ~w_trial[64]};
                end else begin
                    r_out_den <= r_q[61:0] == 62'd0 && w_trial[64] ? 63'd1
                                 : {r_q[61:0], ~w_trial[64]};
                    r_out_num <= r_neg ? -r_mn : r_mn;
                end
            end
            rau_pkg::ST_DIVN_INIT: begin
                r_q   <= r_mn;
                r_rem <= 64'd0;
                r_dvs <= r_x;
                r_cnt <= 7'd63;
            end
            rau_pkg::ST_DIVD_INIT: begin
                r_q   <= r_md;
                r_rem <= 64'd0;
                r_dvs <= r_x;
                r_cnt <= 7'd63;
            end
            default: ;
        endcase
    end

    assign o_busy       = (r_state != rau_pkg::ST_IDLE);
    assign o_valid      = r_valid;
    assign o_res_num    = r_out_num;
    assign o_res_den    = r_out_den;
    assign o_is_greater = r_gt;
    assign o_is_equal   = r_eq;
    assign o_is_less    = r_lt;

endmodule
